### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst is high.
`define SDMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The same check, with the cycle right after reset also left out.
`define SDMT_ASSERT_POST_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (!$past(rst)) |-> (prop)) \
    else $error(msg);

`endif

### rtl/sdmt_pkg.sv
package sdmt_pkg;

  localparam int unsigned WINDOW_W   = 8;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned THR_W      = 19;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned AXIS_CNT_W = 3;
  localparam int unsigned MAG_SCALE  = 200;
  // 200 * 255 fits in 16 bits.
  localparam int unsigned DIV_W      = 16;
  // (threshold + offset) * 200 fits in 28 bits.
  localparam int unsigned LIM_W      = 28;

  localparam logic [THR_W-1:0]    ACC_MAX      = 19'h7FFFF;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd10;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd55;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH    = 1'b0,
    REG_THRESHOLD_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_LIMIT,
    ST_DONE
  } state_t;

endpackage

### rtl/sdmt_in_if.sv
interface sdmt_in_if #(
  parameter int AXIS_BITS = 13
);
  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] first_x;
  logic signed [AXIS_BITS-1:0] first_y;
  logic signed [AXIS_BITS-1:0] first_z;
  logic signed [AXIS_BITS-1:0] second_x;
  logic signed [AXIS_BITS-1:0] second_y;
  logic signed [AXIS_BITS-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

### rtl/sdmt_out_if.sv
interface sdmt_out_if
  import sdmt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               step_seen;
  logic [COUNT_W-1:0] step_total;
  logic [THR_W-1:0]   current_threshold;

  modport source (
    output valid, step_seen, step_total, current_threshold,
    input  ready
  );

  modport sink (
    input  valid, step_seen, step_total, current_threshold,
    output ready
  );
endinterface

### rtl/step_detector_magnitude_threshold.sv
// Step detector with an adaptive magnitude threshold.
// The samples channel carries one beat per pair of three-axis readings; the
// result channel returns exactly one beat for each of them, in order, with the
// step flag, the running step count and the threshold in use.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 sets
// the window length, index 1 the threshold offset. The user must write it only
// while the block is idle; the block itself does not enforce this.
// The six squares come from one shift-and-add multiplier that handles one
// multiplier bit per cycle, and the per-item share of the average comes from a
// restoring divider that takes one quotient bit per cycle; the threshold
// update, the limit product and the compare follow in that order.
// A new sample beat is taken once the previous item has been handed to the
// output register, so a result may wait there while the next item is worked.
// If the receiver stalls with a result still held, the finished item waits in
// the last stage and no further beat is taken until the register frees up.
// Synchronous reset restores the window length of 10 and the offset of 55 and
// clears the accumulator, window count, threshold, step count and output valid flag.
`include "assert_macros.svh"

module step_detector_magnitude_threshold
  import sdmt_pkg::*;
#(
  parameter int AXIS_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sdmt_in_if.sink               samples,
  sdmt_out_if.source            result
);

  localparam int SUM_W     = 2 * AXIS_BITS + 1;
  localparam int BIT_CNT_W = $clog2(AXIS_BITS);
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int CMP_W     = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  function automatic logic [AXIS_BITS-1:0] magnitude(input logic [AXIS_BITS-1:0] v);
    return v[AXIS_BITS-1] ? (~v + AXIS_BITS'(1)) : v;
  endfunction

  state_t                state;
  state_t                state_next;

  logic [WINDOW_W-1:0]   window_length;
  logic [OFFSET_W-1:0]   threshold_offset;
  logic [THR_W-1:0]      magnitude_accumulator;
  logic [WINDOW_W-1:0]   items_in_window;
  logic [THR_W-1:0]      average_threshold;
  logic [COUNT_W-1:0]    step_counter;

  logic [AXIS_BITS-1:0]  axes [NUM_AXES];
  logic [AXIS_BITS-1:0]  mlt;
  logic [SUM_W-1:0]      mcd;
  logic [SUM_W-1:0]      sum;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [AXIS_CNT_W-1:0] axis_cnt;
  logic [DIV_W-1:0]      dvsr;
  logic [SUM_W-1:0]      dvd;
  logic [DIV_W-1:0]      rem;
  logic [SUM_W-1:0]      quo;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [LIM_W-1:0]      lim;

  logic                  out_valid;
  logic                  out_step;
  logic [COUNT_W-1:0]    out_total;
  logic [THR_W-1:0]      out_thr;

  logic                  accept;
  logic                  finish;
  logic                  out_free;
  logic [WINDOW_W-1:0]   win_eff;
  logic [SUM_W-1:0]      sum_next;
  logic                  last_bit;
  logic                  last_axis;
  logic                  last_div;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W:0]        rem_sub;
  logic                  q_bit;
  logic [DIV_W-1:0]      rem_next;
  logic [THR_W-1:0]      contrib;
  logic [THR_W:0]        acc_sum;
  logic [THR_W-1:0]      acc_sat;
  logic [WINDOW_W-1:0]   items_inc;
  logic                  close_win;
  logic [THR_W:0]        lim_base;
  logic [LIM_W-1:0]      lim_next;
  logic                  step_hit;
  logic [COUNT_W-1:0]    step_counter_next;

  assign win_eff   = (window_length == '0) ? WINDOW_W'(1) : window_length;
  assign sum_next  = mlt[0] ? (sum + mcd) : sum;
  assign last_bit  = bit_cnt == BIT_CNT_W'(AXIS_BITS - 1);
  assign last_axis = axis_cnt == AXIS_CNT_W'(NUM_AXES - 1);
  assign last_div  = div_cnt == DIV_CNT_W'(SUM_W - 1);

  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvsr};
  assign q_bit    = rem_sh >= {1'b0, dvsr};
  assign rem_next = q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

  assign contrib   = (quo > SUM_W'(ACC_MAX)) ? ACC_MAX : quo[THR_W-1:0];
  assign acc_sum   = {1'b0, magnitude_accumulator} + {1'b0, contrib};
  assign acc_sat   = acc_sum[THR_W] ? ACC_MAX : acc_sum[THR_W-1:0];
  assign items_inc = items_in_window + WINDOW_W'(1);
  assign close_win = items_inc >= win_eff;

  assign lim_base = {1'b0, average_threshold} + (THR_W + 1)'(threshold_offset);
  assign lim_next = LIM_W'(lim_base * MAG_SCALE);
  assign step_hit = CMP_W'(sum) > CMP_W'(lim);
  assign step_counter_next = step_hit ? (step_counter + COUNT_W'(1)) : step_counter;

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    accept        = 1'b0;
    finish        = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          accept     = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (last_bit && last_axis) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (last_div) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_LIMIT;
      end
      ST_LIMIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length         <= WINDOW_RESET;
      threshold_offset      <= OFFSET_RESET;
      magnitude_accumulator <= '0;
      items_in_window       <= '0;
      average_threshold     <= '0;
      step_counter          <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:    window_length    <= cfg_data[WINDOW_W-1:0];
          REG_THRESHOLD_OFFSET: threshold_offset <= cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_UPDATE) begin
        if (close_win) begin
          items_in_window       <= '0;
          average_threshold     <= acc_sat;
          magnitude_accumulator <= '0;
        end else begin
          items_in_window       <= items_inc;
          magnitude_accumulator <= acc_sat;
        end
      end
      if (finish) begin
        step_counter <= step_counter_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      axes[0]  <= samples.first_x;
      axes[1]  <= samples.first_y;
      axes[2]  <= samples.first_z;
      axes[3]  <= samples.second_x;
      axes[4]  <= samples.second_y;
      axes[5]  <= samples.second_z;
      mlt      <= magnitude(samples.first_x);
      mcd      <= SUM_W'(magnitude(samples.first_x));
      sum      <= '0;
      bit_cnt  <= '0;
      axis_cnt <= '0;
      dvsr     <= DIV_W'(win_eff * MAG_SCALE);
    end else if (state == ST_SQUARE) begin
      sum <= sum_next;
      if (last_bit) begin
        bit_cnt  <= '0;
        axis_cnt <= axis_cnt + AXIS_CNT_W'(1);
        for (int i = 0; i < NUM_AXES - 1; i++) begin
          axes[i] <= axes[i+1];
        end
        mlt <= magnitude(axes[1]);
        mcd <= SUM_W'(magnitude(axes[1]));
        if (last_axis) begin
          dvd     <= sum_next;
          rem     <= '0;
          div_cnt <= '0;
        end
      end else begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        mlt     <= mlt >> 1;
        mcd     <= mcd << 1;
      end
    end else if (state == ST_DIVIDE) begin
      rem     <= rem_next;
      quo     <= {quo[SUM_W-2:0], q_bit};
      dvd     <= dvd << 1;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end else if (state == ST_LIMIT) begin
      lim <= lim_next;
    end
    if (finish) begin
      out_step  <= step_hit;
      out_total <= step_counter_next;
      out_thr   <= average_threshold;
    end
  end

  assign result.valid             = out_valid;
  assign result.step_seen         = out_step;
  assign result.step_total        = out_total;
  assign result.current_threshold = out_thr;

  `SDMT_ASSERT(a_rem_below_divisor, (state == ST_DIVIDE) |-> (rem < dvsr), "remainder not below divisor")
  `SDMT_ASSERT(a_window_count_bounded, (state == ST_LIMIT) |-> (items_in_window < win_eff), "window count past window length")
  `SDMT_ASSERT_POST_RST(a_counter_moves_on_finish, ($past(state) != ST_DONE) |-> $stable(step_counter), "step count changed outside result hand-off")

endmodule
